/* sv/brs_pkg.sv */
// Shared types and constants for the bitmap run search unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package brs_pkg;

	// Bitmap word geometry. Only the low WORD_BITS bits of an input word are searched.
	localparam int WORD_BITS   = 64;
	localparam int BITMAP_W    = 64;
	localparam int OFFSET_BITS = 20;
	localparam int BIT_INDEX_W = 6;
	localparam int IDX_W       = $clog2(WORD_BITS);
	localparam int CNT_W       = $clog2(WORD_BITS + 1);

	// Run length register and the carried run count.
	localparam int RUN_LEN_W = 16;
	localparam int RUN_CNT_W = RUN_LEN_W + 1;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RUN_LENGTH = 2'd0,
		REG_FIND_CLEAR = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [RUN_LEN_W-1:0] run_length;
		logic                 find_clear;
	} brs_cfg_t;

	// Per-word summary handed from the front end to the back end.
	typedef struct packed {
		logic             last;       // final word of the region
		logic [CNT_W-1:0] lead;       // target bits counted up from bit 0
		logic [CNT_W-1:0] top;        // target bits counted down from the top bit
		logic             win_hit;    // a full run lies inside this word
		logic [IDX_W-1:0] win_start;  // start bit of the first such run
	} brs_item_t;

endpackage

`default_nettype wire

/* sv/brs_front.sv */
// Front end: turns one bitmap word into a summary of its target-bit runs.
// Depends on brs_pkg.
`default_nettype none

module brs_front (
	input  wire logic [brs_pkg::BITMAP_W-1:0] bitmap_word,
	input  wire logic                         last_word,
	input  wire brs_pkg::brs_cfg_t            cfg,
	output brs_pkg::brs_item_t                item
);
	import brs_pkg::*;

	logic [WORD_BITS-1:0] tgt;
	logic [RUN_LEN_W-1:0] need;
	logic                 need_fits;
	logic [CNT_W-1:0]     nsel;
	logic [WORD_BITS-1:0] pw [CNT_W];
	logic [WORD_BITS-1:0] win;
	logic                 win_empty;
	logic [CNT_W-1:0]     lead;
	logic [CNT_W-1:0]     top;
	logic [IDX_W-1:0]     win_end;
	logic [CNT_W-1:0]     start_calc;

	assign tgt       = cfg.find_clear ? ~bitmap_word[WORD_BITS-1:0] : bitmap_word[WORD_BITS-1:0];
	assign need      = (cfg.run_length == '0) ? RUN_LEN_W'(1) : cfg.run_length;
	assign need_fits = (need <= RUN_LEN_W'(WORD_BITS));
	assign nsel      = need[CNT_W-1:0];

	// pw[k][b] is set when the 2**k bits ending at bit b are all target bits.
	always_comb begin
		pw[0] = tgt;
		for (int k = 1; k < CNT_W; k++) begin
			pw[k] = pw[k-1] & (pw[k-1] << (1 << (k - 1)));
		end
	end

	// Compose windows of the requested length from the power-of-two windows.
	always_comb begin
		win       = '1;
		win_empty = 1'b1;
		for (int k = 0; k < CNT_W; k++) begin
			if (nsel[k]) begin
				win       = win_empty ? pw[k] : (pw[k] & (win << (1 << k)));
				win_empty = 1'b0;
			end
		end
		if (!need_fits) begin
			win = '0;
		end
	end

	// Run lengths at both ends and the lowest window end.
	always_comb begin
		lead    = CNT_W'(WORD_BITS);
		top     = CNT_W'(WORD_BITS);
		win_end = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!tgt[i]) begin
				lead = CNT_W'(i);
			end
			if (win[i]) begin
				win_end = IDX_W'(i);
			end
		end
		for (int i = 0; i < WORD_BITS; i++) begin
			if (!tgt[i]) begin
				top = CNT_W'(WORD_BITS - 1 - i);
			end
		end
	end

	assign start_calc = CNT_W'(win_end) + CNT_W'(1) - nsel;

	assign item.last      = last_word;
	assign item.lead      = lead;
	assign item.top       = top;
	assign item.win_hit   = |win;
	assign item.win_start = start_calc[IDX_W-1:0];

endmodule

`default_nettype wire

/* sv/brs_queue.sv */
// Two-entry queue of word summaries between the front and back ends.
// Depends on brs_pkg.
`default_nettype none

module brs_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire brs_pkg::brs_item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output brs_pkg::brs_item_t  head_item
);
	import brs_pkg::*;

	brs_item_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

/* sv/brs_back.sv */
// Back end: applies the carried run to each word summary and registers the result.
// Depends on brs_pkg.
`default_nettype none

module brs_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire brs_pkg::brs_cfg_t               cfg,
	input  wire logic                            head_valid,
	input  wire brs_pkg::brs_item_t              head_item,
	output logic                                 pop,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 found,
	output logic [brs_pkg::OFFSET_BITS-1:0]      word_offset,
	output logic [brs_pkg::BIT_INDEX_W-1:0]      bit_index
);
	import brs_pkg::*;

	logic [RUN_CNT_W-1:0]   run_q;
	logic [OFFSET_BITS-1:0] start_word_q;
	logic [IDX_W-1:0]       start_bit_q;
	logic [OFFSET_BITS-1:0] word_cnt_q;
	logic                   hit_rep_q;

	logic                   out_valid_q;
	logic                   found_q;
	logic [OFFSET_BITS-1:0] word_offset_q;
	logic [IDX_W-1:0]       bit_index_q;

	logic [RUN_CNT_W-1:0]   need;
	logic [RUN_CNT_W:0]     carry_sum;
	logic                   carry_hit;
	logic                   hit;
	logic                   emit;
	logic                   restart;
	logic                   whole_word;
	logic [OFFSET_BITS-1:0] hit_word;
	logic [IDX_W-1:0]       hit_bit;

	assign pop = head_valid && (!out_valid_q || !out_stall);

	assign need = (cfg.run_length == '0) ? RUN_CNT_W'(1) : RUN_CNT_W'(cfg.run_length);

	// The carried run reaches the length within the word's leading target bits.
	assign carry_sum  = (RUN_CNT_W + 1)'(run_q) + (RUN_CNT_W + 1)'(head_item.lead);
	assign carry_hit  = (head_item.lead != '0) && (carry_sum >= (RUN_CNT_W + 1)'(need));
	assign hit        = carry_hit || head_item.win_hit;
	assign whole_word = (head_item.lead == CNT_W'(WORD_BITS));

	always_comb begin
		if (carry_hit && (run_q != '0)) begin
			hit_word = start_word_q;
			hit_bit  = start_bit_q;
		end else if (carry_hit) begin
			hit_word = word_cnt_q;
			hit_bit  = '0;
		end else begin
			hit_word = word_cnt_q;
			hit_bit  = head_item.win_start;
		end
	end

	assign emit    = pop && !hit_rep_q && (hit || head_item.last);
	assign restart = pop && head_item.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q        <= '0;
			start_word_q <= '0;
			start_bit_q  <= '0;
			word_cnt_q   <= '0;
			hit_rep_q    <= 1'b0;
		end else if (restart) begin
			run_q        <= '0;
			start_word_q <= '0;
			start_bit_q  <= '0;
			word_cnt_q   <= '0;
			hit_rep_q    <= 1'b0;
		end else if (pop && !hit_rep_q) begin
			if (hit) begin
				hit_rep_q <= 1'b1;
			end else begin
				if (whole_word) begin
					run_q <= run_q + RUN_CNT_W'(WORD_BITS);
					if (run_q == '0) begin
						start_word_q <= word_cnt_q;
						start_bit_q  <= '0;
					end
				end else begin
					run_q        <= RUN_CNT_W'(head_item.top);
					start_word_q <= word_cnt_q;
					start_bit_q  <= IDX_W'(CNT_W'(WORD_BITS) - head_item.top);
				end
				if (word_cnt_q != '1) begin
					word_cnt_q <= word_cnt_q + OFFSET_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_q       <= hit;
			word_offset_q <= hit ? hit_word : '0;
			bit_index_q   <= hit ? hit_bit : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign word_offset = word_offset_q;
	assign bit_index   = BIT_INDEX_W'(bit_index_q);

endmodule

`default_nettype wire

/* sv/bitmap_run_search_unit.sv */
// Top level of the bitmap run search unit: configuration registers, front end,
// summary queue and back end. Depends on brs_pkg, brs_front, brs_queue and brs_back.
`default_nettype none

// Channel   Direction  Handshake              Request contents
// input     in         in_valid / in_stall    bitmap_word, last_word
// output    out        out_valid / out_stall  found, word_offset, bit_index
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One bitmap word is taken every cycle while the queue is not full; the back end's carried run count, one
// add and compare per word, is the loop that sets that rate.
// A word's summary is registered in the queue, and its result then in the output register.
// Reset clears the search state and sets run_length to 1 and find_clear to 1.
// A two-entry queue splits the sides: input stalls only when it is full,
// which happens only while a waiting result is held by out_stall.

module bitmap_run_search_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [brs_pkg::BITMAP_W-1:0]     bitmap_word,
	input  wire logic                             last_word,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  found,
	output logic [brs_pkg::OFFSET_BITS-1:0]       word_offset,
	output logic [brs_pkg::BIT_INDEX_W-1:0]       bit_index,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [brs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [brs_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import brs_pkg::*;

	brs_cfg_t  cfg_q;
	brs_item_t front_item;
	brs_item_t head_item;
	logic      q_full;
	logic      head_valid;
	logic      pop;
	logic      push;

	// Configuration writes are always taken; a write to an unused index is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_length <= RUN_LEN_W'(1);
			cfg_q.find_clear <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_RUN_LENGTH) begin
				cfg_q.run_length <= cfg_data[RUN_LEN_W-1:0];
			end else if (cfg_index == REG_FIND_CLEAR) begin
				cfg_q.find_clear <= cfg_data[0];
			end
		end
	end

	// The front end needs no state of its own: each word is summarized as it
	// arrives and the summary lands directly in the queue.
	brs_front u_front (
		.bitmap_word (bitmap_word),
		.last_word   (last_word),
		.cfg         (cfg_q),
		.item        (front_item)
	);

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	brs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (front_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// The back end owns the carried run, the word counter and the output register.
	brs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head_valid  (head_valid),
		.head_item   (head_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.word_offset (word_offset),
		.bit_index   (bit_index)
	);

endmodule

`default_nettype wire

/* sv/brs_checker.sv */
// Port-level checks for the bitmap run search unit, bound to its top level.
// Depends on brs_pkg and bitmap_run_search_unit.
`default_nettype none

module brs_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_stall,
	input wire logic                             out_valid,
	input wire logic                             out_stall,
	input wire logic                             found,
	input wire logic [brs_pkg::OFFSET_BITS-1:0]  word_offset,
	input wire logic [brs_pkg::BIT_INDEX_W-1:0]  bit_index
);
	import brs_pkg::*;

	// A held result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(word_offset)
			&& $stable(bit_index))
		else $error("result changed while stalled");

	// A not-found result carries a zero position.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (word_offset == '0) && (bit_index == '0))
		else $error("not-found result with nonzero position");

	// The queue only fills behind a result that is being held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without a held result");

	a_stall_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bit_index < BIT_INDEX_W'(WORD_BITS - 1))
			|| (bit_index == BIT_INDEX_W'(WORD_BITS - 1)))
		else $error("bit index beyond word");

endmodule

bind bitmap_run_search_unit brs_checker u_brs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.found       (found),
	.word_offset (word_offset),
	.bit_index   (bit_index)
);

`default_nettype wire
